// File: hw/rtl/alu16f_pkg.sv
// ----------------------------------------------------------------------------
// alu16f_pkg
// Types and constants shared by the 16-bit ALU with held result and flags.
// ----------------------------------------------------------------------------
package alu16f_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned FlagWidth = 4;

  localparam int unsigned FlagCarry = 0;
  localparam int unsigned FlagNzero = 1;
  localparam int unsigned FlagSign  = 2;
  localparam int unsigned FlagNovf  = 3;

  typedef enum logic [2:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpAnd  = 3'd2,
    OpOr   = 3'd3,
    OpXor  = 3'd4,
    OpShl  = 3'd5,
    OpShr  = 3'd6,
    OpTest = 3'd7
  } alu_op_e;

  typedef struct packed {
    logic                 action;
    logic [2:0]           op_mode;
    logic [DataWidth-1:0] bus_a;
    logic [DataWidth-1:0] bus_b;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] data_out;
    logic [FlagWidth-1:0] flags_out;
  } alu_rsp_t;

endpackage

// File: hw/rtl/alu_16bit_flags.sv
// An accepted request's response is registered in the output buffer before it reaches the output.
// Throughput: one request per cycle while in_stall_o is low; a two-entry output
// buffer accepts one more request while the response side stalls.
// Reset: the held result word, the flags and both buffer entries are cleared.
// ----------------------------------------------------------------------------
// alu_16bit_flags
// A 16-bit ALU that reports its held result and flags for every request and
// latches a newly computed result and flag word when the request asks for it.
// ----------------------------------------------------------------------------
module alu_16bit_flags
  import alu16f_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  alu_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output alu_rsp_t out_rsp_o
);

  logic [DataWidth-1:0] result_q, result_d;
  logic [FlagWidth-1:0] flags_q, flags_d;
  alu_rsp_t             out_q, out_d, skid_q, skid_d;
  logic                 out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic                 in_acc, out_pop;
  logic [DataWidth:0]   sum;
  logic [DataWidth-1:0] val;
  logic                 carry, sa, sb, sv, ovf;
  alu_op_e              op;
  alu_rsp_t             rsp_new;

  assign op = alu_op_e'(in_req_i.op_mode);

  always_comb begin
    sum   = '0;
    val   = in_req_i.bus_a;
    carry = in_req_i.bus_a[0];
    unique case (op)
      OpAdd: begin
        sum   = {1'b0, in_req_i.bus_a} + {1'b0, in_req_i.bus_b};
        val   = sum[DataWidth-1:0];
        carry = sum[DataWidth];
      end
      OpSub: begin
        sum   = {1'b0, in_req_i.bus_b} + {1'b0, ~in_req_i.bus_a} + {{DataWidth{1'b0}}, 1'b1};
        val   = sum[DataWidth-1:0];
        carry = sum[DataWidth];
      end
      OpAnd: begin
        val   = in_req_i.bus_a & in_req_i.bus_b;
        carry = val[0];
      end
      OpOr: begin
        val   = in_req_i.bus_a | in_req_i.bus_b;
        carry = val[0];
      end
      OpXor: begin
        val   = in_req_i.bus_a ^ in_req_i.bus_b;
        carry = val[0];
      end
      OpShl: begin
        val   = {in_req_i.bus_a[DataWidth-2:0], 1'b0};
        carry = in_req_i.bus_a[DataWidth-1];
      end
      OpShr: begin
        val   = {1'b0, in_req_i.bus_a[DataWidth-1:1]};
        carry = in_req_i.bus_a[0];
      end
      OpTest: begin
        val   = in_req_i.bus_a;
        carry = val[0];
      end
      default: begin
        val   = in_req_i.bus_a;
        carry = val[0];
      end
    endcase
  end

  assign sa  = in_req_i.bus_a[DataWidth-1];
  assign sb  = in_req_i.bus_b[DataWidth-1];
  assign sv  = val[DataWidth-1];
  assign ovf = (sa == sb) && (sv != sa);

  always_comb begin
    flags_d            = '0;
    flags_d[FlagCarry] = carry;
    flags_d[FlagNzero] = |val;
    flags_d[FlagSign]  = sv;
    flags_d[FlagNovf]  = ~ovf;
  end

  assign in_acc  = in_valid_i && !skid_valid_q;
  assign out_pop = out_valid_q && !out_stall_i;

  assign rsp_new.data_out  = result_q;
  assign rsp_new.flags_out = flags_q;

  always_comb begin
    result_d     = result_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (in_acc && in_req_i.action) begin
      result_d = val;
    end
    if (skid_valid_q) begin
      if (out_pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_pop) begin
        out_d       = rsp_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rsp_new;
        skid_valid_d = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q     <= '0;
      flags_q      <= '0;
      out_q        <= '0;
      skid_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      result_q     <= result_d;
      if (in_acc && in_req_i.action) begin
        flags_q <= flags_d;
      end
      out_q        <= out_d;
      skid_q       <= skid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: verif/alu_16bit_flags_tb.sv
// ----------------------------------------------------------------------------
// alu_16bit_flags_tb
// Self-checking testbench for the 16-bit ALU with held result and flags. A
// short table of directed requests covers the operand extremes, every
// operation and the hold case. Random requests follow. Both sides pause at
// random. Every response is compared with a predictor of the held word and
// flags, or with the value typed into the table.
// ----------------------------------------------------------------------------
module alu_16bit_flags_tb;
  import alu16f_pkg::*;

  typedef struct {
    logic     typed;
    alu_req_t req;
    alu_rsp_t rsp;
  } dir_row_t;

  typedef struct packed {
    logic     typed;
    alu_rsp_t rsp;
  } typed_rsp_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  alu_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  alu_rsp_t out_rsp_o;

  logic [DataWidth-1:0] held_word  = '0;
  logic [FlagWidth-1:0] held_flags = '0;
  typed_rsp_t           typed_rsp_q[$];
  alu_rsp_t             held_rsp_q[$];
  dir_row_t             dir_rows[$];
  int unsigned          mismatch_cnt = 0;

  alu_16bit_flags u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic latch_alu(input alu_req_t r);
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic [DataWidth:0]   sum;
    logic [DataWidth-1:0] v;
    logic                 carry;
    logic                 ovf;
    a = r.bus_a;
    b = r.bus_b;
    case (alu_op_e'(r.op_mode))
      OpAdd: begin
        sum   = {1'b0, a} + {1'b0, b};
        v     = sum[DataWidth-1:0];
        carry = sum[DataWidth];
      end
      OpSub: begin
        v     = b - a;
        carry = (b >= a);
      end
      OpAnd: begin
        v     = a & b;
        carry = v[0];
      end
      OpOr: begin
        v     = a | b;
        carry = v[0];
      end
      OpXor: begin
        v     = a ^ b;
        carry = v[0];
      end
      OpShl: begin
        v     = {a[DataWidth-2:0], 1'b0};
        carry = a[DataWidth-1];
      end
      OpShr: begin
        v     = {1'b0, a[DataWidth-1:1]};
        carry = a[0];
      end
      default: begin
        v     = a;
        carry = v[0];
      end
    endcase
    ovf = (a[DataWidth-1] == b[DataWidth-1]) && (v[DataWidth-1] != a[DataWidth-1]);
    held_word             = v;
    held_flags            = '0;
    held_flags[FlagCarry] = carry;
    held_flags[FlagNzero] = (v != '0);
    held_flags[FlagSign]  = v[DataWidth-1];
    held_flags[FlagNovf]  = ~ovf;
  endtask

  // Accepted requests: queue the held value they report, then update it.
  always @(posedge clk_i) begin : accept_blk
    typed_rsp_t tag;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      tag = typed_rsp_q.pop_front();
      held_rsp_q.push_back(tag.typed ? tag.rsp : alu_rsp_t'({held_word, held_flags}));
      if (in_req_i.action) begin
        latch_alu(in_req_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_blk
    alu_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (held_rsp_q.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        want = held_rsp_q.pop_front();
        if (out_rsp_o.data_out !== want.data_out) begin
          report_mismatch($sformatf("data_out %h, wanted %h", out_rsp_o.data_out,
                                    want.data_out));
        end
        if (out_rsp_o.flags_out !== want.flags_out) begin
          report_mismatch($sformatf("flags_out %h, wanted %h", out_rsp_o.flags_out,
                                    want.flags_out));
        end
      end
    end
  end

  // Response-side stalls: runs without stall, short stalls, a few long ones.
  initial begin : stall_blk
    int unsigned run;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 50) : $urandom_range(6, 1);
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b1;
      run = ($urandom_range(99, 0) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  function automatic int unsigned pick_gap(input int unsigned idx);
    int unsigned p;
    p = $urandom_range(99, 0);
    if ((idx / 150) % 3 == 0) return 0;
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [DataWidth-1:0] pick_operand();
    if ($urandom_range(9, 0) < 7) return DataWidth'($urandom);
    case ($urandom_range(4, 0))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic void add_row(input logic typed, input logic action, input alu_op_e op,
                                  input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] data, input logic [3:0] flags);
    dir_row_t row;
    row.typed = typed;
    row.req   = '{action: action, op_mode: op, bus_a: a, bus_b: b};
    row.rsp   = '{data_out: data, flags_out: flags};
    dir_rows.push_back(row);
  endfunction

  task automatic send_req(input alu_req_t r, input logic typed, input alu_rsp_t rsp,
                          input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_rsp_q.push_back('{typed: typed, rsp: rsp});
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (held_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stim_blk
    alu_req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(1'b1, 1'b0, OpAdd,  16'hFFFF, 16'hFFFF, 16'h0000, 4'h0);
    add_row(1'b1, 1'b1, OpAdd,  16'hFFFF, 16'h0001, 16'h0000, 4'h0);
    add_row(1'b1, 1'b1, OpAdd,  16'h7FFF, 16'h0001, 16'h0000, 4'h9);
    add_row(1'b1, 1'b1, OpSub,  16'h0001, 16'h0000, 16'h8000, 4'h6);
    add_row(1'b1, 1'b1, OpSub,  16'h8000, 16'h8000, 16'hFFFF, 4'h6);
    add_row(1'b1, 1'b1, OpAnd,  16'hFFFF, 16'hFFFF, 16'h0000, 4'h1);
    add_row(1'b1, 1'b1, OpOr,   16'h0000, 16'h0000, 16'hFFFF, 4'hF);
    add_row(1'b1, 1'b1, OpXor,  16'hFFFF, 16'h0000, 16'h0000, 4'h8);
    add_row(1'b1, 1'b1, OpShl,  16'h8000, 16'h0000, 16'hFFFF, 4'hF);
    add_row(1'b1, 1'b1, OpShr,  16'h0001, 16'hFFFF, 16'h0000, 4'h9);
    add_row(1'b1, 1'b1, OpTest, 16'h8001, 16'h8000, 16'h0000, 4'h9);
    add_row(1'b1, 1'b0, OpSub,  16'hFFFF, 16'h0000, 16'h8001, 4'hF);
    add_row(1'b1, 1'b0, OpTest, 16'h5A5A, 16'hA5A5, 16'h8001, 4'hF);
    add_row(1'b1, 1'b1, OpShl,  16'h4000, 16'h4000, 16'h8001, 4'hF);
    add_row(1'b1, 1'b1, OpTest, 16'h0000, 16'hFFFF, 16'h8000, 4'h6);
    add_row(1'b0, 1'b1, OpAdd,  16'h1234, 16'h4321, '0, '0);
    add_row(1'b0, 1'b1, OpSub,  16'h5555, 16'hAAAA, '0, '0);
    add_row(1'b0, 1'b1, OpAnd,  16'hA5A5, 16'h5A5A, '0, '0);
    add_row(1'b0, 1'b1, OpOr,   16'hA5A5, 16'h5A5A, '0, '0);
    add_row(1'b0, 1'b1, OpXor,  16'hAAAA, 16'h5555, '0, '0);
    add_row(1'b0, 1'b1, OpShr,  16'hFFFE, 16'h0000, '0, '0);
    add_row(1'b0, 1'b1, OpShl,  16'h0001, 16'h8000, '0, '0);
    add_row(1'b0, 1'b1, OpTest, 16'h7FFF, 16'h7FFF, '0, '0);
    add_row(1'b0, 1'b0, OpShr,  16'h0000, 16'h0000, '0, '0);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, pick_gap(i + 150));
    end
    drain();

    for (int unsigned i = 0; i < 1825; i++) begin
      if (i == 600 || i == 1200) begin
        drain();
      end
      r.action  = ($urandom_range(99, 0) < 85);
      r.op_mode = 3'($urandom_range(7, 0));
      r.bus_a   = pick_operand();
      r.bus_b   = pick_operand();
      send_req(r, 1'b0, '0, pick_gap(i));
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog_blk
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/alu16f_pkg.sv
hw/rtl/alu_16bit_flags.sv
verif/alu_16bit_flags_tb.sv
